[rtl/core/esalu_pkg.sv]
package esalu_pkg;

    localparam int DATA_W = 32;
    localparam int QDIV_W = 33;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        T_U8  = 3'd0,
        T_S8  = 3'd1,
        T_U16 = 3'd2,
        T_S16 = 3'd3,
        T_S32 = 3'd4,
        T_U32 = 3'd5
    } t_etype;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_ANDN = 5'd8, OP_SHIFT = 5'd9,
        OP_MAX = 5'd10, OP_MIN = 5'd11, OP_MEAN = 5'd12, OP_NEG = 5'd13,
        OP_EQ = 5'd14, OP_GT = 5'd15, OP_GE = 5'd16, OP_LT = 5'd17, OP_LE = 5'd18,
        OP_NE = 5'd19
    } t_op;

    localparam logic [1:0] ADDR_ETYPE = 2'd0;
    localparam logic [1:0] ADDR_OP    = 2'd1;

    // decoded word passed from front to back
    typedef struct packed {
        logic              valid_type;
        logic              sgn;
        logic [1:0]        wsel;     // 0: 8, 1: 16, 2: 32
        logic [4:0]        op;
        logic signed [QDIV_W-1:0] a;  // decoded values, sign or zero extended by type
        logic signed [QDIV_W-1:0] b;
        logic [DATA_W-1:0] pa;        // masked patterns
        logic [DATA_W-1:0] pb;
    } t_item;

endpackage

[rtl/core/elementwise_saturating_alu.sv]
// Path: an accepted input word passes through the input queue and then the
//   back pipeline; the 8-stage radix-16 divider sets the pipeline depth.
// Throughput: one word per cycle unless the output is stalled by m_axis_tready.
// Reset: synchronous active-low; clears handshake state and both config
//   registers (u8, add).
module elementwise_saturating_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value[31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import esalu_pkg::*;

    logic [2:0] r_etype;
    logic [4:0] r_op;
    logic       qv, qr;
    t_item      qi;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype <= '0;
            r_op    <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_ETYPE[0]) r_etype <= pwdata[2:0];
            else                           r_op    <= pwdata[4:0];
        end
    end
    assign prdata = paddr[2] ? {27'd0, r_op} : {29'd0, r_etype};

    esalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_a     (s_axis_tdata[31:0]),
        .i_b     (s_axis_tdata[63:32]),
        .i_etype (r_etype),
        .i_op    (r_op),
        .o_valid (qv),
        .i_ready (qr),
        .o_item  (qi)
    );

    esalu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qv),
        .o_ready (qr),
        .i_item  (qi),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

[rtl/core/esalu_front.sv]
module esalu_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [esalu_pkg::DATA_W-1:0] i_a,
    input  logic [esalu_pkg::DATA_W-1:0] i_b,
    input  logic [2:0]                   i_etype,
    input  logic [4:0]                   i_op,
    output logic                         o_valid,
    input  logic                         i_ready,
    output esalu_pkg::t_item             o_item
);
    import esalu_pkg::*;

    t_item                          n_item;
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0]   r_cnt;
    t_item                          r_q [QUEUE_DEPTH];
    logic                           push, pop;

    always_comb begin
        n_item = '0;
        n_item.op = i_op;
        n_item.valid_type = 1'b1;
        unique case (i_etype)
            T_U8: begin
                n_item.wsel = 2'd0;
                n_item.pa = {24'd0, i_a[7:0]};
                n_item.pb = {24'd0, i_b[7:0]};
                n_item.a = {25'd0, i_a[7:0]};
                n_item.b = {25'd0, i_b[7:0]};
            end
            T_S8: begin
                n_item.wsel = 2'd0;
                n_item.sgn = 1'b1;
                n_item.pa = {24'd0, i_a[7:0]};
                n_item.pb = {24'd0, i_b[7:0]};
                n_item.a = {{25{i_a[7]}}, i_a[7:0]};
                n_item.b = {{25{i_b[7]}}, i_b[7:0]};
            end
            T_U16: begin
                n_item.wsel = 2'd1;
                n_item.pa = {16'd0, i_a[15:0]};
                n_item.pb = {16'd0, i_b[15:0]};
                n_item.a = {17'd0, i_a[15:0]};
                n_item.b = {17'd0, i_b[15:0]};
            end
            T_S16: begin
                n_item.wsel = 2'd1;
                n_item.sgn = 1'b1;
                n_item.pa = {16'd0, i_a[15:0]};
                n_item.pb = {16'd0, i_b[15:0]};
                n_item.a = {{17{i_a[15]}}, i_a[15:0]};
                n_item.b = {{17{i_b[15]}}, i_b[15:0]};
            end
            T_S32: begin
                n_item.wsel = 2'd2;
                n_item.sgn = 1'b1;
                n_item.pa = i_a;
                n_item.pb = i_b;
                n_item.a = {i_a[31], i_a};
                n_item.b = {i_b[31], i_b};
            end
            T_U32: begin
                n_item.wsel = 2'd2;
                n_item.pa = i_a;
                n_item.pb = i_b;
                n_item.a = {1'b0, i_a};
                n_item.b = {1'b0, i_b};
            end
            default: n_item.valid_type = 1'b0;
        endcase
    end

    assign o_ready = (r_cnt != QUEUE_DEPTH[$clog2(QUEUE_DEPTH):0]);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{$clog2(QUEUE_DEPTH){1'b0}}, push}
                           - {{$clog2(QUEUE_DEPTH){1'b0}}, pop};
        end
        if (push) r_q[r_wp] <= n_item;
    end

endmodule

[rtl/core/esalu_div.sv]
module esalu_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [esalu_pkg::QDIV_W-1:0]  i_a,
    input  logic [esalu_pkg::QDIV_W-1:0]  i_b,
    input  logic                          i_sgn,
    output logic [esalu_pkg::QDIV_W-1:0]  o_q,
    output logic [esalu_pkg::QDIV_W-1:0]  o_r
);
    import esalu_pkg::*;

    localparam int W = DATA_W;
    localparam int S = W / 4;

    // magnitude restoring divider, four quotient bits per stage
    logic [W-1:0] r_n   [S+1];
    logic [W-1:0] r_d   [S+1];
    logic [W-1:0] r_rem [S+1];
    logic         r_na  [S+1];
    logic         r_nb  [S+1];
    logic         r_z   [S+1];
    logic [W-1:0] ma, mb;

    assign ma = (i_sgn && i_a[W]) ? W'(-i_a) : i_a[W-1:0];
    assign mb = (i_sgn && i_b[W]) ? W'(-i_b) : i_b[W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= ma;
            r_d[0]   <= mb;
            r_rem[0] <= '0;
            r_na[0]  <= i_sgn && i_a[W];
            r_nb[0]  <= i_sgn && i_b[W];
            r_z[0]   <= (mb == '0);
        end
    end

    for (genvar s = 0; s < S; s++) begin : g_st
        logic [W:0]   rem;
        logic [W-1:0] n;
        always_comb begin
            rem = {1'b0, r_rem[s]};
            n   = r_n[s];
            for (int k = 0; k < 4; k++) begin
                rem = {rem[W-1:0], n[W-1]};
                n   = {n[W-2:0], 1'b0};
                if (rem >= {1'b0, r_d[s]}) begin
                    rem  = rem - {1'b0, r_d[s]};
                    n[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[s+1]   <= n;
                r_rem[s+1] <= rem[W-1:0];
                r_d[s+1]   <= r_d[s];
                r_na[s+1]  <= r_na[s];
                r_nb[s+1]  <= r_nb[s];
                r_z[s+1]   <= r_z[s];
            end
        end
    end

    logic [QDIV_W-1:0] q, r;
    always_comb begin
        q = {1'b0, r_n[S]};
        r = {1'b0, r_rem[S]};
        if (r_na[S] != r_nb[S]) q = -q;
        if (r_na[S]) r = -r;
        // floor modulo: result takes the divisor's sign
        if (r != '0 && (r_na[S] != r_nb[S]))
            r = r + (r_nb[S] ? -{1'b0, r_d[S]} : {1'b0, r_d[S]});
        if (r_z[S]) begin
            q = '0;
            r = '0;
        end
    end
    assign o_q = q;
    assign o_r = r;

endmodule

[rtl/core/esalu_back.sv]
module esalu_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  esalu_pkg::t_item             i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [esalu_pkg::DATA_W-1:0] o_data
);
    import esalu_pkg::*;

    localparam int W   = DATA_W;
    localparam int LAT = W / 4 + 2;

    // pipeline: stage 0 register, divider stages, finishing register
    logic [LAT-1:0] r_v;
    logic           en;
    t_item          r_s0;
    t_item          r_dl [W/4+1];
    logic [W+1:0]   r_prod;
    logic signed [QDIV_W:0] r_sum;
    logic [QDIV_W-1:0] dq, dr;
    logic [W-1:0]   r_out, fin;
    logic           r_ov;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[LAT-2:0], i_valid};
            r_ov <= r_v[LAT-1];
        end
        if (en) begin
            r_s0   <= i_item;
            // low bits of the product only: 32-bit types wrap, narrow ones fit
            r_prod <= {i_item.a[QDIV_W-1], i_item.a} * {i_item.b[QDIV_W-1], i_item.b};
            r_sum  <= (i_item.op == OP_SUB) ?
                      {i_item.a[QDIV_W-1], i_item.a} - {i_item.b[QDIV_W-1], i_item.b} :
                      (i_item.op == OP_NEG) ? -{i_item.a[QDIV_W-1], i_item.a} :
                      {i_item.a[QDIV_W-1], i_item.a} + {i_item.b[QDIV_W-1], i_item.b};
            r_dl[0] <= r_s0;
            for (int s = 0; s < W/4; s++) r_dl[s+1] <= r_dl[s];
            r_out  <= fin;
        end
    end

    // arithmetic results carried alongside the divider
    logic [W+1:0]   r_ar [W/4+1];
    logic           r_cmp_gt [W/4+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            unique case (r_s0.op)
                OP_MUL:  r_ar[0] <= r_prod;
                OP_MEAN: r_ar[0] <= {r_sum[QDIV_W], r_sum[QDIV_W:1]}
                                    + {{W{1'b0}}, 1'b0, r_sum[0] & r_sum[1]};
                default: r_ar[0] <= r_sum[W+1:0];
            endcase
            r_cmp_gt[0] <= ($signed(r_s0.a) > $signed(r_s0.b));
            for (int s = 0; s < W/4; s++) begin
                r_ar[s+1]     <= r_ar[s];
                r_cmp_gt[s+1] <= r_cmp_gt[s];
            end
        end
    end

    esalu_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s0.a),
        .i_b   (r_s0.b),
        .i_sgn (r_s0.sgn),
        .o_q   (dq),
        .o_r   (dr)
    );

    t_item        it;
    logic [W+1:0] ar;
    logic         gt, eq;
    logic signed [W+1:0] v;
    logic signed [W+1:0] hi, lo;
    logic [W-1:0] m;
    logic signed [W:0] cnt;
    logic [5:0]   bits;

    always_comb begin
        it   = r_dl[W/4];
        ar   = r_ar[W/4];
        gt   = r_cmp_gt[W/4];
        eq   = (it.a == it.b);
        bits = (it.wsel == 2'd0) ? 6'd8 : (it.wsel == 2'd1) ? 6'd16 : 6'd32;
        m    = (it.wsel == 2'd0) ? W'(32'hFF) : (it.wsel == 2'd1) ? W'(32'hFFFF) : '1;
        hi   = it.sgn ? {3'b0, m[W-1:1]} : {2'b0, m};
        lo   = it.sgn ? ~{3'b0, m[W-1:1]} : '0;
        cnt  = it.b;
        v    = '0;
        fin  = '0;
        case (it.op)
            OP_ADD, OP_SUB, OP_MUL, OP_MEAN, OP_NEG: v = ar;
            OP_DIV: v = {dq[QDIV_W-1], dq};
            OP_MOD: v = {dr[QDIV_W-1], dr};
            default: v = '0;
        endcase
        case (it.op)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_MEAN, OP_NEG: begin
                if (it.wsel != 2'd2) begin
                    if (v > hi) v = hi;
                    if (v < lo) v = lo;
                end
                fin = v[W-1:0] & m;
            end
            OP_AND:  fin = it.pa & it.pb;
            OP_OR:   fin = it.pa | it.pb;
            OP_XOR:  fin = it.pa ^ it.pb;
            OP_ANDN: fin = it.pa & ~it.pb & m;
            OP_SHIFT: begin
                if (!cnt[W]) fin = (cnt >= $signed({27'd0, bits})) ? '0
                                 : (it.pa << cnt[4:0]) & m;
                else fin = (-cnt >= $signed({27'd0, bits})) ? '0
                         : it.pa >> W'(-cnt);
            end
            OP_MAX: fin = gt ? it.pa : it.pb;
            OP_MIN: fin = (!gt && !eq) ? it.pa : it.pb;
            OP_EQ:  fin = eq ? W'(255) : '0;
            OP_GT:  fin = gt ? W'(255) : '0;
            OP_GE:  fin = (gt || eq) ? W'(255) : '0;
            OP_LT:  fin = (!gt && !eq) ? W'(255) : '0;
            OP_LE:  fin = !gt ? W'(255) : '0;
            OP_NE:  fin = !eq ? W'(255) : '0;
            default: fin = '0;
        endcase
        if (!it.valid_type) fin = '0;
    end

endmodule
